>>> hw/rtl/cks_pkg.sv
// Shared types and constants of the chaotic keystream cipher.
package cks_pkg;

  localparam int unsigned GroupBytes = 12;

  localparam logic [31:0] KeyXReset   = 32'd456372;
  localparam logic [31:0] KeyYReset   = 32'd4372;
  localparam logic [31:0] KeyZReset   = 32'd56;
  localparam logic [31:0] MaskReset   = 32'd65395;
  localparam logic [31:0] MultReset   = 32'd787;
  localparam logic [4:0]  ShiftReset  = 5'd5;
  localparam logic [7:0]  HeaderReset = 8'd22;

  typedef enum logic [2:0] {
    RegKeyX       = 3'd0,
    RegKeyY       = 3'd1,
    RegKeyZ       = 3'd2,
    RegMask       = 3'd3,
    RegMult       = 3'd4,
    RegShift      = 3'd5,
    RegHeaderSkip = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    CmdPass   = 2'd0,
    CmdLoad   = 2'd1,
    CmdUpdate = 2'd2,
    CmdUse    = 2'd3
  } cmd_kind_e;

  typedef enum logic [2:0] {
    SeqIdle = 3'd0,
    SeqCoup = 3'd1,
    SeqMulX = 3'd2,
    SeqMulY = 3'd3,
    SeqMulZ = 3'd4,
    SeqSumZ = 3'd5
  } seq_state_e;

  typedef struct packed {
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic [31:0] key_z;
    logic [31:0] coupling_mask;
    logic [31:0] multiplier;
    logic [4:0]  shift_amount;
    logic [7:0]  header_skip;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [3:0]  pos;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } res_t;

endpackage

>>> hw/rtl/cks_fifo.sv
// Small first-in first-out queue built from registers.
module cks_fifo #(
  parameter int unsigned DataWidth = 8,
  parameter int unsigned Depth     = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DataWidth-1:0] data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic [DataWidth-1:0] data_o,
  output logic                 empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [DataWidth-1:0] mem_q [Depth];
  logic [AddrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AddrW:0]       count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (AddrW + 1)'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/cks_front.sv
// Front end: accepts bytes and tags each with its place in the stream.
module cks_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [7:0]      data_byte_i,
  input  logic            start_req_i,
  input  logic            last_in_i,
  input  logic [7:0]      header_skip_i,
  input  logic            cmd_full_i,
  output logic            cmd_push_o,
  output cks_pkg::cmd_t   cmd_o
);

  logic [7:0] hdr_cnt_q, hdr_cnt_d, hdr_cnt_eff;
  logic [3:0] grp_pos_q, grp_pos_d, grp_pos_eff;
  logic       loaded_q, loaded_d, loaded_eff;
  logic       accept;

  assign accept     = push_i && !cmd_full_i;
  assign cmd_push_o = accept;

  // A start flag restarts the stream before this byte is looked at.
  assign hdr_cnt_eff = start_req_i ? '0 : hdr_cnt_q;
  assign grp_pos_eff = start_req_i ? '0 : grp_pos_q;
  assign loaded_eff  = start_req_i ? 1'b0 : loaded_q;

  always_comb begin
    hdr_cnt_d  = hdr_cnt_q;
    grp_pos_d  = grp_pos_q;
    loaded_d   = loaded_q;
    cmd_o.data = data_byte_i;
    cmd_o.last = last_in_i;
    cmd_o.pos  = grp_pos_eff;
    cmd_o.kind = cks_pkg::CmdUse;
    if (hdr_cnt_eff < header_skip_i) begin
      cmd_o.kind = cks_pkg::CmdPass;
      hdr_cnt_d  = hdr_cnt_eff + 1'b1;
      grp_pos_d  = grp_pos_eff;
      loaded_d   = loaded_eff;
    end else begin
      if (grp_pos_eff == '0) begin
        cmd_o.kind = loaded_eff ? cks_pkg::CmdUpdate : cks_pkg::CmdLoad;
      end
      hdr_cnt_d = hdr_cnt_eff;
      loaded_d  = 1'b1;
      grp_pos_d = (grp_pos_eff == 4'(cks_pkg::GroupBytes - 1)) ? '0 : grp_pos_eff + 1'b1;
    end
    if (last_in_i) begin
      hdr_cnt_d = '0;
      grp_pos_d = '0;
      loaded_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0;
      grp_pos_q <= '0;
      loaded_q  <= 1'b0;
    end else if (accept) begin
      hdr_cnt_q <= hdr_cnt_d;
      grp_pos_q <= grp_pos_d;
      loaded_q  <= loaded_d;
    end
  end

endmodule

>>> hw/rtl/cks_back.sv
// Back end: holds the three maps, precomputes their next values and
// enciphers the tagged bytes.
module cks_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cks_pkg::cfg_t   cfg_i,
  input  logic            cfg_write_i,
  input  logic            cmd_empty_i,
  input  cks_pkg::cmd_t   cmd_i,
  output logic            cmd_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output cks_pkg::res_t   res_o
);

  cks_pkg::seq_state_e state_q, state_d;

  logic [31:0] map_x_q, map_y_q, map_z_q;
  logic [31:0] nxt_x_q, nxt_y_q, nxt_z_q;
  logic [31:0] coup_q, prod_q;
  logic        nxt_valid_q, nxt_valid_d;
  logic        fire, maps_change, restart;

  logic [1:0]  mul_sel;
  logic        coup_load, prod_load;
  logic        sum_x, sum_y, sum_z;
  logic [31:0] mul_op, sum_map, sum_val;

  logic [31:0] word_x, word_y, word_z, word;

  // An update may only go ahead once the next map values are ready.
  assign fire = !cmd_empty_i && !res_full_i &&
                ((cmd_i.kind != cks_pkg::CmdUpdate) || nxt_valid_q);
  assign cmd_pop_o   = fire;
  assign res_push_o  = fire;
  assign maps_change = fire && ((cmd_i.kind == cks_pkg::CmdLoad) ||
                                (cmd_i.kind == cks_pkg::CmdUpdate));
  assign restart     = maps_change || cfg_write_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      cks_pkg::SeqIdle: state_d = cks_pkg::SeqIdle;
      cks_pkg::SeqCoup: state_d = cks_pkg::SeqMulX;
      cks_pkg::SeqMulX: state_d = cks_pkg::SeqMulY;
      cks_pkg::SeqMulY: state_d = cks_pkg::SeqMulZ;
      cks_pkg::SeqMulZ: state_d = cks_pkg::SeqSumZ;
      cks_pkg::SeqSumZ: state_d = cks_pkg::SeqIdle;
      default:          state_d = cks_pkg::SeqIdle;
    endcase
    if (restart) begin
      state_d = cks_pkg::SeqCoup;
    end
  end

  always_comb begin
    mul_sel     = 2'd0;
    coup_load   = 1'b0;
    prod_load   = 1'b0;
    sum_x       = 1'b0;
    sum_y       = 1'b0;
    sum_z       = 1'b0;
    nxt_valid_d = nxt_valid_q;
    case (state_q)
      cks_pkg::SeqCoup: coup_load = 1'b1;
      cks_pkg::SeqMulX: begin
        prod_load = 1'b1;
        mul_sel   = 2'd0;
      end
      cks_pkg::SeqMulY: begin
        prod_load = 1'b1;
        mul_sel   = 2'd1;
        sum_x     = 1'b1;
      end
      cks_pkg::SeqMulZ: begin
        prod_load = 1'b1;
        mul_sel   = 2'd2;
        sum_y     = 1'b1;
      end
      cks_pkg::SeqSumZ: begin
        sum_z       = 1'b1;
        nxt_valid_d = 1'b1;
      end
      default: ;
    endcase
    if (restart) begin
      nxt_valid_d = 1'b0;
    end
  end

  always_comb begin
    case (mul_sel)
      2'd0:    mul_op = map_x_q;
      2'd1:    mul_op = map_y_q;
      default: mul_op = map_z_q;
    endcase
    if (sum_x) begin
      sum_map = map_x_q;
    end else if (sum_y) begin
      sum_map = map_y_q;
    end else begin
      sum_map = map_z_q;
    end
  end

  assign sum_val = prod_q + (sum_map >> cfg_i.shift_amount) + coup_q;

  // Map words as they stand once this byte's group has begun.
  always_comb begin
    case (cmd_i.kind)
      cks_pkg::CmdLoad: begin
        word_x = cfg_i.key_x;
        word_y = cfg_i.key_y;
        word_z = cfg_i.key_z;
      end
      cks_pkg::CmdUpdate: begin
        word_x = nxt_x_q;
        word_y = nxt_y_q;
        word_z = nxt_z_q;
      end
      default: begin
        word_x = map_x_q;
        word_y = map_y_q;
        word_z = map_z_q;
      end
    endcase
    if (cmd_i.pos < 4'd4) begin
      word = word_x;
    end else if (cmd_i.pos < 4'd8) begin
      word = word_y;
    end else begin
      word = word_z;
    end
  end

  always_comb begin
    res_o.last = cmd_i.last;
    if (cmd_i.kind == cks_pkg::CmdPass) begin
      res_o.out_byte = cmd_i.data;
    end else begin
      case (cmd_i.pos[1:0])
        2'd0:    res_o.out_byte = cmd_i.data ^ word[7:0];
        2'd1:    res_o.out_byte = cmd_i.data ^ word[15:8];
        2'd2:    res_o.out_byte = cmd_i.data ^ word[23:16];
        default: res_o.out_byte = cmd_i.data ^ word[31:24];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cks_pkg::SeqIdle;
      nxt_valid_q <= 1'b0;
      map_x_q     <= '0;
      map_y_q     <= '0;
      map_z_q     <= '0;
    end else begin
      state_q     <= state_d;
      nxt_valid_q <= nxt_valid_d;
      if (maps_change) begin
        map_x_q <= word_x;
        map_y_q <= word_y;
        map_z_q <= word_z;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (coup_load) begin
      coup_q <= cfg_i.coupling_mask & (map_x_q ^ map_y_q ^ map_z_q);
    end
    if (prod_load) begin
      prod_q <= cfg_i.multiplier * mul_op;
    end
    if (sum_x) begin
      nxt_x_q <= sum_val;
    end
    if (sum_y) begin
      nxt_y_q <= sum_val;
    end
    if (sum_z) begin
      nxt_z_q <= sum_val;
    end
  end

endmodule

>>> hw/rtl/chaotic_keystream_xor.sv
// Top level of the chaotic keystream cipher: registers, queues and both ends.
//
//   Channel   Handshake             Payload
//   input     push / full           data_byte_i, start_req_i, last_in_i
//   result    empty / pop           out_byte_o, last_out_o
//   config    cfg_valid_i / ready   cfg_index_i, cfg_data_i
//
// One byte is taken and one result given per cycle unless a queue is full or a group
// start waits; a byte is held in the command queue and its result in the result queue.
// The next map values are worked out by one shared 32-bit multiplier after each
// map change, so a group start only waits after a register write.
// Reset clears the counters, queues and maps; a full result queue stalls the back end.
module chaotic_keystream_xor #(
  parameter int unsigned CmdDepth = 4,
  parameter int unsigned ResDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        start_req_i,
  input  logic        last_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cks_pkg::cfg_t cfg_q;
  cks_pkg::cmd_t front_cmd, back_cmd;
  cks_pkg::res_t back_res, out_res;

  logic [$bits(cks_pkg::cmd_t)-1:0] cmd_rd_data;
  logic [$bits(cks_pkg::res_t)-1:0] res_rd_data;
  logic cfg_write, cmd_push, cmd_full, cmd_pop, cmd_empty, res_push, res_full;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_x         <= cks_pkg::KeyXReset;
      cfg_q.key_y         <= cks_pkg::KeyYReset;
      cfg_q.key_z         <= cks_pkg::KeyZReset;
      cfg_q.coupling_mask <= cks_pkg::MaskReset;
      cfg_q.multiplier    <= cks_pkg::MultReset;
      cfg_q.shift_amount  <= cks_pkg::ShiftReset;
      cfg_q.header_skip   <= cks_pkg::HeaderReset;
    end else if (cfg_write) begin
      case (cks_pkg::reg_idx_e'(cfg_index_i))
        cks_pkg::RegKeyX:       cfg_q.key_x         <= cfg_data_i;
        cks_pkg::RegKeyY:       cfg_q.key_y         <= cfg_data_i;
        cks_pkg::RegKeyZ:       cfg_q.key_z         <= cfg_data_i;
        cks_pkg::RegMask:       cfg_q.coupling_mask <= cfg_data_i;
        cks_pkg::RegMult:       cfg_q.multiplier    <= cfg_data_i;
        cks_pkg::RegShift:      cfg_q.shift_amount  <= cfg_data_i[4:0];
        cks_pkg::RegHeaderSkip: cfg_q.header_skip   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  cks_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .data_byte_i   (data_byte_i),
    .start_req_i   (start_req_i),
    .last_in_i     (last_in_i),
    .header_skip_i (cfg_q.header_skip),
    .cmd_full_i    (cmd_full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (front_cmd)
  );

  assign full = cmd_full;

  cks_fifo #(
    .DataWidth ($bits(cks_pkg::cmd_t)),
    .Depth     (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_rd_data),
    .empty_o (cmd_empty)
  );

  assign back_cmd = cmd_rd_data;

  cks_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_write_i (cfg_write),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  cks_fifo #(
    .DataWidth ($bits(cks_pkg::res_t)),
    .Depth     (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_rd_data),
    .empty_o (empty)
  );

  assign out_res    = res_rd_data;
  assign out_byte_o = out_res.out_byte;
  assign last_out_o = out_res.last;

endmodule
